// File: rtl/supply_voltage_supervisor_top_defines.svh
// ----------------------------------------------------------------------------
// Supply voltage supervisor assertion macros
// Shared assertion forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_VOLTAGE_SUPERVISOR_TOP_DEFINES_SVH
`define SUPPLY_VOLTAGE_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication
`define SVS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/svs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supply voltage supervisor package
// Widths, Q16 thresholds, filter coefficients, codes and the multiplier request.
// ----------------------------------------------------------------------------
package svs_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 20;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 49;
   localparam int Q16_W   = 32;
   localparam int CODE_W  = 12;
   localparam int SCALE_W = 20;

   // filter coefficients, Q16, each pair sums to one
   localparam logic [MUL_B_W-1:0] RAIL_COEF_A = 20'd64225;
   localparam logic [MUL_B_W-1:0] RAIL_COEF_B = 20'd1311;
   localparam logic [MUL_B_W-1:0] BUS_COEF_A  = 20'd58982;
   localparam logic [MUL_B_W-1:0] BUS_COEF_B  = 20'd6554;
   localparam logic [ACC_W-1:0]   ROUND_HALF  = 49'd32768;

   // thresholds in Q16 millivolts
   localparam logic [Q16_W-1:0] BUS_OVER_Q16    = 32'd10000 << 16;
   localparam logic [Q16_W-1:0] BUS_UNDER_Q16   = 32'd4700 << 16;
   localparam logic [Q16_W-1:0] RAIL_OVER_Q16   = 32'd3200 << 16;
   localparam logic [Q16_W-1:0] ADAPTER_MIN_Q16 = 32'd8800 << 16;
   localparam logic [Q16_W-1:0] BATT_MIN_Q16    = 32'd6000 << 16;
   localparam logic [Q16_W-1:0] BATT_MAX_Q16    = 32'd8300 << 16;
   localparam logic [Q16_W-1:0] ALARM1_Q16      = 32'd7300 << 16;
   localparam logic [Q16_W-1:0] ALARM2_Q16      = 32'd6760 << 16;
   localparam logic [Q16_W-1:0] ALARM3_Q16      = 32'd6200 << 16;

   // regulator setpoints and led periods
   localparam logic [11:0] SP_LOW       = 12'd730;
   localparam logic [11:0] SP_NORMAL    = 12'd770;
   localparam logic [8:0]  PERIOD_NONE  = 9'd0;
   localparam logic [8:0]  PERIOD_FAST  = 9'd50;
   localparam logic [8:0]  PERIOD_MED   = 9'd100;
   localparam logic [8:0]  PERIOD_TRIP  = 9'd300;

   // configuration register indexes
   localparam logic [1:0] CSR_ADC_OFFSET = 2'd0;
   localparam logic [1:0] CSR_BUS_SCALE  = 2'd1;
   localparam logic [1:0] CSR_RAIL_SCALE = 2'd2;

   typedef enum logic [2:0] {
      LED_NONE     = 3'd0,
      LED_YELLOW   = 3'd1,
      LED_RED_ON   = 3'd2,
      LED_RED      = 3'd3,
      LED_RED_BLUE = 3'd4,
      LED_RGB      = 3'd5,
      LED_PURPLE   = 3'd6,
      LED_GREEN    = 3'd7
   } led_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_BUS_HIGH  = 2'd1,
      FAULT_BUS_LOW   = 2'd2,
      FAULT_RAIL_HIGH = 2'd3
   } fault_type;

   typedef enum logic [1:0] {
      SRC_NONE    = 2'd0,
      SRC_ADAPTER = 2'd1,
      SRC_BATTERY = 2'd2
   } src_type;

   // one issue to the shared multiplier
   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

// File: rtl/svs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supply voltage supervisor shared multiplier
// One unsigned 32 x 20 multiply per issue, product registered.
// ----------------------------------------------------------------------------
module svs_mul import svs_pkg::*; (
   input  logic              clock,
   input  mul_req_type       mul_req,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;

   // registered product, held while no issue
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
      end
   end

   assign prod = prod_ff;

endmodule

// File: rtl/supply_voltage_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supply voltage supervisor top level
// Filters bus and rail samples and runs the protection and low-battery alarm.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: one beat per item. req_action 0 is a sample (bus and rail
//   ADC codes feed the low-pass filters), 1 is a check (protection chain and
//   low-battery alarm on the filtered voltages). Every beat yields one rsp_*
//   beat with the filtered voltages, status and the events of that item.
//   csr_* channel: writes adc_offset (0), bus_scale (1), rail_scale (2);
//   other indexes are dropped. csr_ready is always high; write only while
//   no item is in flight.
//   Flow: a sample beat makes six passes through the single shared 32 x 20
//   multiplier (two scalings, two filter taps per channel) and then loads
//   the output register; a check beat registers its protection and alarm
//   results, then loads. One item is in flight at a time: a new item is
//   taken only once the last result has been loaded.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver stalls with a result still held, the
//   following item finishes its work and waits to load until rsp_ready.
//   Reset: filters, source, alarm stage, fault and rail enable go to zero,
//   registers to their defaults (offset 0, bus 264000, rail 52800).
// ----------------------------------------------------------------------------
`include "supply_voltage_supervisor_top_defines.svh"

module supply_voltage_supervisor_top import svs_pkg::*; #(
   parameter int ADC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [CODE_W-1:0]   req_bus_code,
   input  logic [CODE_W-1:0]   req_rail_code,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_bus_mv,
   output logic [15:0]         rsp_rail_mv,
   output logic [1:0]          rsp_fault_code,
   output logic [1:0]          rsp_source_kind,
   output logic [1:0]          rsp_alarm_level,
   output logic [2:0]          rsp_led_pattern,
   output logic [8:0]          rsp_led_period,
   output logic                rsp_setpoint_write,
   output logic [11:0]         rsp_setpoint_code,
   output logic                rsp_rail_on,
   output logic                rsp_shutdown_request,
   // configuration channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [SCALE_W-1:0]  csr_wdata
);

   localparam int SUM_W = CODE_W + 2;
   localparam logic [CODE_W-1:0] CodeMask =
      (ADC_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((32'd1 << ADC_BITS) - 32'd1);

   localparam logic [1:0] ALARM_NONE  = 2'd0;
   localparam logic [1:0] ALARM_ONE   = 2'd1;
   localparam logic [1:0] ALARM_TWO   = 2'd2;
   localparam logic [1:0] ALARM_FINAL = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      STEP_RAIL_SCALE,
      STEP_BUS_SCALE,
      STEP_RAIL_TAP_A,
      STEP_RAIL_TAP_B,
      STEP_BUS_TAP_A,
      STEP_BUS_TAP_B,
      STEP_BUS_FINISH
   } step_type;

   state_type           state_ff;
   step_type            step_ff;

   // configuration
   logic signed [7:0]   offset_ff;
   logic [SCALE_W-1:0]  bus_scale_ff;
   logic [SCALE_W-1:0]  rail_scale_ff;

   // latched item
   logic                action_ff;
   logic [CODE_W-1:0]   bus_code_ff;
   logic [CODE_W-1:0]   rail_code_ff;

   // supervisor state
   logic [Q16_W-1:0]    bus_filt_ff;
   logic [Q16_W-1:0]    rail_filt_ff;
   src_type             src_ff;
   logic [1:0]          alarm_ff;
   fault_type           fault_ff;
   logic                rail_on_ff;

   // per-item events
   led_type             led_ff;
   logic [8:0]          period_ff;
   logic                spw_ff;
   logic [11:0]         spc_ff;
   logic                shut_ff;

   // filter datapath
   logic [Q16_W-1:0]    xr_ff;
   logic [Q16_W-1:0]    xb_ff;
   logic [ACC_W-1:0]    acc_ff;

   // response register
   logic                rsp_valid_ff;
   logic [15:0]         rsp_bus_mv_ff;
   logic [15:0]         rsp_rail_mv_ff;
   fault_type           rsp_fault_ff;
   src_type             rsp_src_ff;
   logic [1:0]          rsp_alarm_ff;
   led_type             rsp_led_ff;
   logic [8:0]          rsp_period_ff;
   logic                rsp_spw_ff;
   logic [11:0]         rsp_spc_ff;
   logic                rsp_rail_on_ff;
   logic                rsp_shutdown_ff;

   mul_req_type         mul_req;
   logic [PROD_W-1:0]   prod;

   logic signed [SUM_W-1:0] bus_sum;
   logic signed [SUM_W-1:0] rail_sum;
   logic [MUL_A_W-1:0]  bus_opnd;
   logic [MUL_A_W-1:0]  rail_opnd;
   logic [Q16_W-1:0]    prod_sat;
   logic [ACC_W-1:0]    tap_sum;
   logic [Q16_W-1:0]    filt_new;
   logic                out_free;
   logic                req_fire;

   // check results
   fault_type           fault_c;
   src_type             src_c;
   logic                rail_on_c;
   logic [1:0]          alarm_c;
   led_type             led_c;
   logic [8:0]          period_c;
   logic                spw_c;
   logic [11:0]         spc_c;
   logic                shut_c;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // offset-corrected codes, clipped at zero
   assign bus_sum   = signed'({2'b00, bus_code_ff & CodeMask}) + SUM_W'(offset_ff);
   assign rail_sum  = signed'({2'b00, rail_code_ff & CodeMask}) + SUM_W'(offset_ff);
   assign bus_opnd  = (bus_sum > 0) ? MUL_A_W'(unsigned'(bus_sum)) : '0;
   assign rail_opnd = (rail_sum > 0) ? MUL_A_W'(unsigned'(rail_sum)) : '0;

   // scaled sample saturates at the top of the Q16 range
   assign prod_sat  = (|prod[PROD_W-1:Q16_W]) ? {Q16_W{1'b1}} : prod[Q16_W-1:0];

   // second filter tap plus held first tap and rounding
   assign tap_sum   = acc_ff + prod[ACC_W-1:0];
   assign filt_new  = tap_sum[Q16_W+15:16];

   // multiplier operand select per step
   always_comb begin
      mul_req.en = (state_ff == ST_SAMPLE) && (step_ff != STEP_BUS_FINISH);
      mul_req.a  = '0;
      mul_req.b  = '0;
      unique case (step_ff)
         STEP_RAIL_SCALE: begin
            mul_req.a = rail_opnd;
            mul_req.b = rail_scale_ff;
         end
         STEP_BUS_SCALE: begin
            mul_req.a = bus_opnd;
            mul_req.b = bus_scale_ff;
         end
         STEP_RAIL_TAP_A: begin
            mul_req.a = rail_filt_ff;
            mul_req.b = RAIL_COEF_A;
         end
         STEP_RAIL_TAP_B: begin
            mul_req.a = xr_ff;
            mul_req.b = RAIL_COEF_B;
         end
         STEP_BUS_TAP_A: begin
            mul_req.a = bus_filt_ff;
            mul_req.b = BUS_COEF_A;
         end
         STEP_BUS_TAP_B: begin
            mul_req.a = xb_ff;
            mul_req.b = BUS_COEF_B;
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   svs_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // protection chain then low-battery alarm
   always_comb begin
      fault_c   = fault_ff;
      src_c     = src_ff;
      rail_on_c = rail_on_ff;
      alarm_c   = alarm_ff;
      led_c     = LED_NONE;
      period_c  = PERIOD_NONE;
      spw_c     = 1'b0;
      spc_c     = '0;
      shut_c    = 1'b0;

      priority if (bus_filt_ff > BUS_OVER_Q16) begin
         rail_on_c = 1'b0;
         fault_c   = FAULT_BUS_HIGH;
         led_c     = LED_RED_BLUE;
         period_c  = PERIOD_TRIP;
         shut_c    = 1'b1;
      end else if (bus_filt_ff < BUS_UNDER_Q16) begin
         rail_on_c = 1'b0;
         fault_c   = FAULT_BUS_LOW;
         led_c     = LED_RED;
         period_c  = PERIOD_TRIP;
         shut_c    = 1'b1;
      end else if (rail_filt_ff > RAIL_OVER_Q16) begin
         rail_on_c = 1'b0;
         fault_c   = FAULT_RAIL_HIGH;
         led_c     = LED_RGB;
         period_c  = PERIOD_TRIP;
         shut_c    = 1'b1;
      end else if (bus_filt_ff > ADAPTER_MIN_Q16 && src_ff == SRC_NONE) begin
         spw_c     = 1'b1;
         spc_c     = SP_NORMAL;
         rail_on_c = 1'b1;
         src_c     = SRC_ADAPTER;
         fault_c   = FAULT_NONE;
         led_c     = LED_PURPLE;
         period_c  = PERIOD_FAST;
      end else if (bus_filt_ff >= BATT_MIN_Q16 && bus_filt_ff <= BATT_MAX_Q16
                   && src_ff == SRC_NONE) begin
         spw_c     = 1'b1;
         spc_c     = SP_NORMAL;
         rail_on_c = 1'b1;
         src_c     = SRC_BATTERY;
         fault_c   = FAULT_NONE;
         led_c     = LED_GREEN;
         period_c  = PERIOD_FAST;
      end else begin
         led_c     = LED_NONE;
      end

      unique case (alarm_ff)
         ALARM_NONE: begin
            if (bus_filt_ff < ALARM1_Q16) begin
               led_c    = LED_YELLOW;
               period_c = PERIOD_FAST;
               alarm_c  = ALARM_ONE;
            end
         end
         ALARM_ONE: begin
            if (bus_filt_ff < ALARM2_Q16) begin
               spw_c    = 1'b1;
               spc_c    = SP_LOW;
               fault_c  = FAULT_BUS_LOW;
               led_c    = LED_RED_ON;
               period_c = PERIOD_FAST;
               alarm_c  = ALARM_TWO;
            end
         end
         ALARM_TWO: begin
            if (bus_filt_ff < ALARM3_Q16) begin
               spw_c    = 1'b1;
               spc_c    = SP_LOW;
               fault_c  = FAULT_BUS_LOW;
               led_c    = LED_RED;
               period_c = PERIOD_MED;
               alarm_c  = ALARM_FINAL;
            end
         end
         default: begin
            alarm_c = ALARM_FINAL;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         bus_scale_ff  <= 20'd264000;
         rail_scale_ff <= 20'd52800;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ADC_OFFSET: offset_ff     <= signed'(csr_wdata[7:0]);
            CSR_BUS_SCALE:  bus_scale_ff  <= csr_wdata;
            CSR_RAIL_SCALE: rail_scale_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer, supervisor state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_RAIL_SCALE;
         bus_filt_ff  <= '0;
         rail_filt_ff <= '0;
         src_ff       <= SRC_NONE;
         alarm_ff     <= ALARM_NONE;
         fault_ff     <= FAULT_NONE;
         rail_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  action_ff    <= req_action;
                  bus_code_ff  <= req_bus_code;
                  rail_code_ff <= req_rail_code;
                  led_ff       <= LED_NONE;
                  period_ff    <= PERIOD_NONE;
                  spw_ff       <= 1'b0;
                  spc_ff       <= '0;
                  shut_ff      <= 1'b0;
                  step_ff      <= STEP_RAIL_SCALE;
                  state_ff     <= req_action ? ST_CHECK : ST_SAMPLE;
               end
            end

            ST_SAMPLE: begin
               unique case (step_ff)
                  STEP_RAIL_SCALE: begin
                     step_ff <= STEP_BUS_SCALE;
                  end
                  STEP_BUS_SCALE: begin
                     xr_ff   <= prod_sat;
                     step_ff <= STEP_RAIL_TAP_A;
                  end
                  STEP_RAIL_TAP_A: begin
                     xb_ff   <= prod_sat;
                     step_ff <= STEP_RAIL_TAP_B;
                  end
                  STEP_RAIL_TAP_B: begin
                     acc_ff  <= prod[ACC_W-1:0] + ROUND_HALF;
                     step_ff <= STEP_BUS_TAP_A;
                  end
                  STEP_BUS_TAP_A: begin
                     rail_filt_ff <= filt_new;
                     step_ff      <= STEP_BUS_TAP_B;
                  end
                  STEP_BUS_TAP_B: begin
                     acc_ff  <= prod[ACC_W-1:0] + ROUND_HALF;
                     step_ff <= STEP_BUS_FINISH;
                  end
                  default: begin
                     bus_filt_ff <= filt_new;
                     step_ff     <= STEP_RAIL_SCALE;
                     state_ff    <= ST_DONE;
                  end
               endcase
            end

            ST_CHECK: begin
               fault_ff   <= fault_c;
               src_ff     <= src_c;
               rail_on_ff <= rail_on_c;
               alarm_ff   <= alarm_c;
               led_ff     <= led_c;
               period_ff  <= period_c;
               spw_ff     <= spw_c;
               spc_ff     <= spc_c;
               shut_ff    <= shut_c;
               state_ff   <= ST_DONE;
            end

            default: begin
               // load the result beat once the output register is free
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_bus_mv_ff   <= bus_filt_ff[Q16_W-1:16];
                  rsp_rail_mv_ff  <= rail_filt_ff[Q16_W-1:16];
                  rsp_fault_ff    <= fault_ff;
                  rsp_src_ff      <= src_ff;
                  rsp_alarm_ff    <= alarm_ff;
                  rsp_led_ff      <= led_ff;
                  rsp_period_ff   <= period_ff;
                  rsp_spw_ff      <= spw_ff;
                  rsp_spc_ff      <= spc_ff;
                  rsp_rail_on_ff  <= rail_on_ff;
                  rsp_shutdown_ff <= shut_ff;
                  state_ff        <= ST_IDLE;
               end
            end
         endcase
      end
   end

   // response ports
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bus_mv           = rsp_bus_mv_ff;
   assign rsp_rail_mv          = rsp_rail_mv_ff;
   assign rsp_fault_code       = rsp_fault_ff;
   assign rsp_source_kind      = rsp_src_ff;
   assign rsp_alarm_level      = rsp_alarm_ff;
   assign rsp_led_pattern      = rsp_led_ff;
   assign rsp_led_period       = rsp_period_ff;
   assign rsp_setpoint_write   = rsp_spw_ff;
   assign rsp_setpoint_code    = rsp_spc_ff;
   assign rsp_rail_on          = rsp_rail_on_ff;
   assign rsp_shutdown_request = rsp_shutdown_ff;

   // checks
   `SVS_ASSERT_NEXT(a_accept_leaves_idle, req_fire && action_ff == action_ff, state_ff != ST_IDLE, "accepted beat did not start work")
   `SVS_ASSERT_NEXT(a_alarm_latched, alarm_ff == ALARM_FINAL, alarm_ff == ALARM_FINAL, "final alarm stage left without reset")
   `SVS_ASSERT_IMPLY(a_rail_needs_source, rail_on_ff, src_ff != SRC_NONE, "rail enabled with no source detected")
   `SVS_ASSERT_IMPLY(a_trip_drops_rail, rsp_valid_ff && rsp_shutdown_ff, !rsp_rail_on_ff, "shutdown request with rail still on")
   `SVS_ASSERT_IMPLY(a_setpoint_code, rsp_valid_ff && rsp_spw_ff, rsp_spc_ff == SP_LOW || rsp_spc_ff == SP_NORMAL, "setpoint write with unknown code")

endmodule

// File: sim/tb_supply_voltage_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supply voltage supervisor testbench
// Drives sample and check beats into the supervisor and mirrors its filters,
// protection chain and low-battery alarm in a cycle-free model. Every result
// beat is compared field by field against the oldest predicted result. The
// stimulus steers the filtered voltages toward the protection and alarm
// thresholds so that detection, trips and every alarm stage are reached.
// ----------------------------------------------------------------------------
module tb_supply_voltage_supervisor_top;
   import svs_pkg::*;

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   // index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // low-battery alarm stages
   localparam logic [1:0] STAGE_NONE  = 2'd0;
   localparam logic [1:0] STAGE_WARN  = 2'd1;
   localparam logic [1:0] STAGE_LOW   = 2'd2;
   localparam logic [1:0] STAGE_FINAL = 2'd3;

   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_MV   = 20;

   typedef struct packed {
      logic [15:0] bus_mv;
      logic [15:0] rail_mv;
      fault_type   fault_code;
      src_type     source_kind;
      logic [1:0]  alarm_level;
      led_type     led_pattern;
      logic [8:0]  led_period;
      logic        setpoint_write;
      logic [11:0] setpoint_code;
      logic        rail_on;
      logic        shutdown_request;
   } supervisor_report_t;

   // mirror of the supervisor state and the results it owes
   class supervisor_mirror;
      logic signed [7:0]  adc_offset;
      logic [19:0]        bus_scale;
      logic [19:0]        rail_scale;
      logic [31:0]        bus_q16;
      logic [31:0]        rail_q16;
      src_type            source;
      logic [1:0]         alarm_stage;
      fault_type          fault;
      logic               rail_en;
      supervisor_report_t due_reports[$];
      int                 mismatch_count;

      function new();
         adc_offset     = 8'sd0;
         bus_scale      = 20'd264000;
         rail_scale     = 20'd52800;
         bus_q16        = 32'd0;
         rail_q16       = 32'd0;
         source         = SRC_NONE;
         alarm_stage    = STAGE_NONE;
         fault          = FAULT_NONE;
         rail_en        = 1'b0;
         mismatch_count = 0;
      endfunction

      function void write_reg(input logic [1:0] index, input logic [19:0] data);
         case (index)
            CSR_ADC_OFFSET: adc_offset = data[7:0];
            CSR_BUS_SCALE:  bus_scale  = data;
            CSR_RAIL_SCALE: rail_scale = data;
            default: ;
         endcase
      endfunction

      // adc code to q16 millivolts, clamped at both ends
      function logic [31:0] code_to_q16(input logic [11:0] code, input logic [19:0] scale);
         longint sum;
         longint prod;
         sum = longint'(code) + longint'(adc_offset);
         if (sum <= 0) return 32'd0;
         prod = sum * longint'(scale);
         if (prod > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
         return prod[31:0];
      endfunction

      // first-order low-pass, round half up
      function logic [31:0] smooth(input logic [31:0] st, input logic [31:0] x,
                                   input logic [19:0] keep, input logic [19:0] take);
         logic [63:0] acc;
         acc = {32'd0, st} * {44'd0, keep} + {32'd0, x} * {44'd0, take} + 64'd32768;
         return acc[47:16];
      endfunction

      // one accepted beat: advance the state and queue its result
      function void accept_item(input logic act, input logic [11:0] bus_code,
                                input logic [11:0] rail_code);
         supervisor_report_t r;
         r.led_pattern      = LED_NONE;
         r.led_period       = PERIOD_NONE;
         r.setpoint_write   = 1'b0;
         r.setpoint_code    = 12'd0;
         r.shutdown_request = 1'b0;
         if (act == ACT_SAMPLE) begin
            rail_q16 = smooth(rail_q16, code_to_q16(rail_code, rail_scale),
                              RAIL_COEF_A, RAIL_COEF_B);
            bus_q16  = smooth(bus_q16, code_to_q16(bus_code, bus_scale),
                              BUS_COEF_A, BUS_COEF_B);
         end else begin
            // protection chain, first match wins
            if (bus_q16 > BUS_OVER_Q16) begin
               rail_en = 1'b0;
               fault = FAULT_BUS_HIGH;
               r.led_pattern = LED_RED_BLUE;
               r.led_period = PERIOD_TRIP;
               r.shutdown_request = 1'b1;
            end else if (bus_q16 < BUS_UNDER_Q16) begin
               rail_en = 1'b0;
               fault = FAULT_BUS_LOW;
               r.led_pattern = LED_RED;
               r.led_period = PERIOD_TRIP;
               r.shutdown_request = 1'b1;
            end else if (rail_q16 > RAIL_OVER_Q16) begin
               rail_en = 1'b0;
               fault = FAULT_RAIL_HIGH;
               r.led_pattern = LED_RGB;
               r.led_period = PERIOD_TRIP;
               r.shutdown_request = 1'b1;
            end else if (bus_q16 > ADAPTER_MIN_Q16 && source == SRC_NONE) begin
               r.setpoint_write = 1'b1;
               r.setpoint_code = SP_NORMAL;
               rail_en = 1'b1;
               source = SRC_ADAPTER;
               fault = FAULT_NONE;
               r.led_pattern = LED_PURPLE;
               r.led_period = PERIOD_FAST;
            end else if (bus_q16 >= BATT_MIN_Q16 && bus_q16 <= BATT_MAX_Q16 &&
                         source == SRC_NONE) begin
               r.setpoint_write = 1'b1;
               r.setpoint_code = SP_NORMAL;
               rail_en = 1'b1;
               source = SRC_BATTERY;
               fault = FAULT_NONE;
               r.led_pattern = LED_GREEN;
               r.led_period = PERIOD_FAST;
            end
            // latched alarm runs last and overrides the chain
            case (alarm_stage)
               STAGE_NONE: begin
                  if (bus_q16 < ALARM1_Q16) begin
                     r.led_pattern = LED_YELLOW;
                     r.led_period = PERIOD_FAST;
                     alarm_stage = STAGE_WARN;
                  end
               end
               STAGE_WARN: begin
                  if (bus_q16 < ALARM2_Q16) begin
                     r.setpoint_write = 1'b1;
                     r.setpoint_code = SP_LOW;
                     fault = FAULT_BUS_LOW;
                     r.led_pattern = LED_RED_ON;
                     r.led_period = PERIOD_FAST;
                     alarm_stage = STAGE_LOW;
                  end
               end
               STAGE_LOW: begin
                  if (bus_q16 < ALARM3_Q16) begin
                     r.setpoint_write = 1'b1;
                     r.setpoint_code = SP_LOW;
                     fault = FAULT_BUS_LOW;
                     r.led_pattern = LED_RED;
                     r.led_period = PERIOD_MED;
                     alarm_stage = STAGE_FINAL;
                  end
               end
               default: ;
            endcase
         end
         r.bus_mv      = bus_q16[31:16];
         r.rail_mv     = rail_q16[31:16];
         r.fault_code  = fault;
         r.source_kind = source;
         r.alarm_level = alarm_stage;
         r.rail_on     = rail_en;
         due_reports.push_back(r);
      endfunction

      function void check_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatch_count++;
         end
      endfunction

      // one result beat against the oldest prediction
      function void compare_report(input supervisor_report_t got);
         supervisor_report_t want;
         if (due_reports.size() == 0) begin
            $error("result beat with no prediction waiting");
            mismatch_count++;
            return;
         end
         want = due_reports.pop_front();
         check_field("bus_mv", want.bus_mv, got.bus_mv);
         check_field("rail_mv", want.rail_mv, got.rail_mv);
         check_field("fault_code", want.fault_code, got.fault_code);
         check_field("source_kind", want.source_kind, got.source_kind);
         check_field("alarm_level", want.alarm_level, got.alarm_level);
         check_field("led_pattern", want.led_pattern, got.led_pattern);
         check_field("led_period", want.led_period, got.led_period);
         check_field("setpoint_write", want.setpoint_write, got.setpoint_write);
         check_field("setpoint_code", want.setpoint_code, got.setpoint_code);
         check_field("rail_on", want.rail_on, got.rail_on);
         check_field("shutdown_request", want.shutdown_request, got.shutdown_request);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [11:0] req_bus_code = 12'd0;
   logic [11:0] req_rail_code = 12'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_bus_mv;
   logic [15:0] rsp_rail_mv;
   logic [1:0]  rsp_fault_code;
   logic [1:0]  rsp_source_kind;
   logic [1:0]  rsp_alarm_level;
   logic [2:0]  rsp_led_pattern;
   logic [8:0]  rsp_led_period;
   logic        rsp_setpoint_write;
   logic [11:0] rsp_setpoint_code;
   logic        rsp_rail_on;
   logic        rsp_shutdown_request;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ADC_OFFSET;
   logic [19:0] csr_wdata = 20'd0;

   supervisor_mirror mirror;
   int send_gap_pct = 16;
   int recv_stall_pct = 83;
   int items_sent = 0;
   int quiet_cycles = 0;

   supply_voltage_supervisor_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_bus_code         (req_bus_code),
      .req_rail_code        (req_rail_code),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_bus_mv           (rsp_bus_mv),
      .rsp_rail_mv          (rsp_rail_mv),
      .rsp_fault_code       (rsp_fault_code),
      .rsp_source_kind      (rsp_source_kind),
      .rsp_alarm_level      (rsp_alarm_level),
      .rsp_led_pattern      (rsp_led_pattern),
      .rsp_led_period       (rsp_led_period),
      .rsp_setpoint_write   (rsp_setpoint_write),
      .rsp_setpoint_code    (rsp_setpoint_code),
      .rsp_rail_on          (rsp_rail_on),
      .rsp_shutdown_request (rsp_shutdown_request),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #1 clock = ~clock;

   // result side: compare accepted beats, stall at random
   always @(posedge clock) begin : take_reports
      supervisor_report_t seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.bus_mv           = rsp_bus_mv;
            seen.rail_mv          = rsp_rail_mv;
            seen.fault_code       = fault_type'(rsp_fault_code);
            seen.source_kind      = src_type'(rsp_source_kind);
            seen.alarm_level      = rsp_alarm_level;
            seen.led_pattern      = led_type'(rsp_led_pattern);
            seen.led_period       = rsp_led_period;
            seen.setpoint_write   = rsp_setpoint_write;
            seen.setpoint_code    = rsp_setpoint_code;
            seen.rail_on          = rsp_rail_on;
            seen.shutdown_request = rsp_shutdown_request;
            mirror.compare_report(seen);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one request beat, with random gaps in front of it
   task automatic send_item(input logic act, input logic [11:0] bus_code,
                            input logic [11:0] rail_code);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_bus_code  <= bus_code;
      req_rail_code <= rail_code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mirror.accept_item(act, bus_code, rail_code);
      items_sent++;
   endtask

   // register write beat; the caller lowers csr_valid after the last one
   task automatic write_csr(input logic [1:0] index, input logic [19:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mirror.write_reg(index, data);
   endtask

   // stop sending until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (mirror.due_reports.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // adc code that moves a filter as close to mv as one sample allows
   function automatic logic [11:0] code_for(input logic [31:0] state, input int mv,
                                            input logic [19:0] scale,
                                            input logic [19:0] keep,
                                            input logic [19:0] take);
      longint want;
      longint code;
      if (scale == 20'd0) return $urandom_range(0, 4095);
      want = ((longint'(mv) <<< 16) - longint'(state) * longint'(keep)) / longint'(take);
      if (want < 0) want = 0;
      code = (want + longint'(scale) / 2) / longint'(scale) - longint'(mirror.adc_offset);
      if (code < 0) code = 0;
      if (code > 4095) code = 4095;
      return code[11:0];
   endfunction

   function automatic bit settled(input logic [31:0] state, input int mv);
      longint diff;
      diff = longint'(state) - (longint'(mv) <<< 16);
      if (diff < 0) diff = -diff;
      return diff < (longint'(SETTLE_MV) <<< 16);
   endfunction

   // sample beats that pull both filters toward the targets
   task automatic steer_toward(input int bus_mv, input int rail_mv, input int max_samples);
      int n;
      for (n = 0; n < max_samples; n++) begin
         if (settled(mirror.bus_q16, bus_mv) && settled(mirror.rail_q16, rail_mv)) break;
         send_item(ACT_SAMPLE,
                   code_for(mirror.bus_q16, bus_mv, mirror.bus_scale, BUS_COEF_A, BUS_COEF_B),
                   code_for(mirror.rail_q16, rail_mv, mirror.rail_scale,
                            RAIL_COEF_A, RAIL_COEF_B));
      end
   endtask

   // directed walk through detection, every alarm stage and every trip
   task automatic run_directed();
      int detect_mv;
      detect_mv = ($urandom_range(0, 1) != 0) ? 9500 : 7800;
      write_csr(CSR_ADC_OFFSET, 20'd0);
      write_csr(CSR_BUS_SCALE, 20'hFFFFF);
      write_csr(CSR_RAIL_SCALE, 20'hFFFFF);
      csr_valid <= 1'b0;
      // code extremes
      send_item(ACT_SAMPLE, 12'hFFF, 12'hFFF);
      send_item(ACT_SAMPLE, 12'h000, 12'h000);
      // adapter or battery detection
      steer_toward(detect_mv, 3000, 6);
      send_item(ACT_CHECK, 12'h000, 12'hFFF);
      // first alarm stage
      steer_toward(7000, 3000, 6);
      send_item(ACT_CHECK, 12'hFFF, 12'h000);
      // undervoltage trip with the second alarm stage in the same beat
      steer_toward(4500, 3000, 6);
      send_item(ACT_CHECK, 12'h000, 12'h000);
      // final alarm stage
      steer_toward(6100, 3000, 6);
      send_item(ACT_CHECK, 12'hFFF, 12'hFFF);
      // bus overvoltage, alarm stays latched
      steer_toward(12000, 3000, 6);
      send_item(ACT_CHECK, 12'h000, 12'h000);
      // rail overvoltage
      steer_toward(8000, 3300, 6);
      send_item(ACT_CHECK, 12'h000, 12'h000);
      // quiet check, source already known
      steer_toward(8000, 3100, 6);
      send_item(ACT_CHECK, 12'h000, 12'h000);
      // negative offset sum clamps to zero
      wait_drained();
      write_csr(CSR_ADC_OFFSET, 20'h00080);
      write_csr(CSR_UNUSED, 20'hFFFFF);
      csr_valid <= 1'b0;
      send_item(ACT_SAMPLE, 12'd127, 12'd128);
      send_item(ACT_CHECK, 12'hFFF, 12'hFFF);
      // product above 32 bits saturates
      wait_drained();
      write_csr(CSR_ADC_OFFSET, 20'h0007F);
      csr_valid <= 1'b0;
      send_item(ACT_SAMPLE, 12'hFFF, 12'hFFF);
      send_item(ACT_CHECK, 12'h000, 12'h000);
   endtask

   // registers and idling for one random segment
   task automatic apply_setting(input int seg);
      logic [19:0] offset_word;
      logic [19:0] bus_word;
      logic [19:0] rail_word;
      case (seg)
         0: begin
            offset_word = 20'd0;
            bus_word    = 20'd264000;
            rail_word   = 20'd52800;
         end
         1: begin
            offset_word = 20'h0007F;
            bus_word    = 20'hFFFFF;
            rail_word   = 20'd0;
         end
         2: begin
            offset_word = $urandom_range(0, 255);
            bus_word    = $urandom_range(200000, 400000);
            rail_word   = $urandom_range(40000, 300000);
         end
         3: begin
            offset_word = 20'h00080;
            bus_word    = 20'd0;
            rail_word   = 20'hFFFFF;
         end
         4: begin
            offset_word = $urandom_range(0, 20'hFFFFF);
            bus_word    = $urandom_range(0, 20'hFFFFF);
            rail_word   = $urandom_range(0, 20'hFFFFF);
         end
         default: begin
            offset_word = $urandom_range(0, 40) - 20;
            bus_word    = 20'd264000;
            rail_word   = $urandom_range(40000, 70000);
         end
      endcase
      if (seg < 2) begin
         send_gap_pct   = 16;
         recv_stall_pct = 83;
      end else if (seg < 4) begin
         send_gap_pct   = 83;
         recv_stall_pct = 16;
      end else begin
         send_gap_pct   = 0;
         recv_stall_pct = 0;
      end
      write_csr(CSR_ADC_OFFSET, offset_word);
      write_csr(CSR_UNUSED, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_BUS_SCALE, bus_word);
      write_csr(CSR_RAIL_SCALE, rail_word);
      csr_valid <= 1'b0;
   endtask

   // mostly steered sample runs ending in a check, the rest raw noise
   task automatic run_random(input int n_items);
      int stop_at;
      int bus_mv;
      int rail_mv;
      int bus_marks[8];
      bus_marks = '{10000, 4700, 8800, 6000, 8300, 7300, 6760, 6200};
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 3) == 0)
               bus_mv = $urandom_range(0, 14000);
            else
               bus_mv = bus_marks[$urandom_range(0, 7)] + int'($urandom_range(0, 600)) - 300;
            if ($urandom_range(0, 1) != 0)
               rail_mv = 2900 + int'($urandom_range(0, 600));
            else
               rail_mv = $urandom_range(0, 3600);
            steer_toward(bus_mv, rail_mv, $urandom_range(1, 10));
            send_item(ACT_CHECK, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end else begin
            send_item($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      int seg;
      mirror = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (seg = 0; seg < 6; seg++) begin
         wait_drained();
         apply_setting(seg);
         run_random(317);
      end
      // let the last results land, then look for strays
      wait_drained();
      repeat (20) @(posedge clock);
      if (mirror.mismatch_count == 0 && mirror.due_reports.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/svs_pkg.sv
rtl/svs_mul.sv
rtl/supply_voltage_supervisor_top.sv
sim/tb_supply_voltage_supervisor_top.sv
